// ===== sv/heading_pid_with_wrap_top_assert.svh =====
// assertion macros for the heading controller
`ifndef HEADING_PID_WITH_WRAP_TOP_ASSERT_SVH
`define HEADING_PID_WITH_WRAP_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define HPW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HPW_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HPW_ASSERT(lbl, clk, rst_n, prop, msg)
`define HPW_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

// ===== sv/hpw_pkg.sv =====
// types and constants shared by the heading controller files
package hpw_pkg;
    localparam int ANGLE_W        = 16;
    localparam int ERR_W          = 17;
    localparam int GAIN_W         = 16;
    localparam int CENTER_W       = 10;
    localparam int MARGIN_W       = 9;
    localparam int DEADBAND_W     = 8;
    localparam int DRIVE_W        = 10;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int GAIN_FRAC_BITS = 8;
    localparam int ERR_MAX        = 65535;
    localparam int ERR_MIN        = -65536;
    localparam int DRIVE_MAX      = 1023;

    localparam logic [GAIN_W-1:0]     GAIN_P_RST   = 16'd256;
    localparam logic [GAIN_W-1:0]     GAIN_I_RST   = 16'd0;
    localparam logic [GAIN_W-1:0]     GAIN_D_RST   = 16'd0;
    localparam logic [CENTER_W-1:0]   CENTER_RST   = 10'd150;
    localparam logic [MARGIN_W-1:0]   MARGIN_RST   = 9'd40;
    localparam logic [DEADBAND_W-1:0] DEADBAND_RST = 8'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P,
        CFG_GAIN_I,
        CFG_GAIN_D,
        CFG_DRIVE_CENTER,
        CFG_DRIVE_MARGIN,
        CFG_DEADBAND_OFFSET
    } t_cfg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0]     gain_p;
        logic [GAIN_W-1:0]     gain_i;
        logic [GAIN_W-1:0]     gain_d;
        logic [CENTER_W-1:0]   drive_center;
        logic [DEADBAND_W-1:0] deadband_offset;
        logic [DRIVE_W-1:0]    drive_lo;
        logic [DRIVE_W-1:0]    drive_hi;
    } t_cfg;
endpackage

// ===== sv/hpw_req_if.sv =====
// request channel carrying measured and target heading
interface hpw_req_if;
    import hpw_pkg::*;
    logic               valid;
    logic               ready;
    logic [ANGLE_W-1:0] measured_angle;
    logic [ANGLE_W-1:0] target_angle_in;

    modport source (output valid, output measured_angle, output target_angle_in,
                    input ready);
    modport sink   (input valid, input measured_angle, input target_angle_in,
                    output ready);
endinterface

// ===== sv/hpw_rsp_if.sv =====
// result channel carrying drive value and clamp flag
interface hpw_rsp_if;
    import hpw_pkg::*;
    logic               valid;
    logic               ready;
    logic [DRIVE_W-1:0] drive_value;
    logic               clamped;

    modport source (output valid, output drive_value, output clamped, input ready);
    modport sink   (input valid, input drive_value, input clamped, output ready);
endinterface

// ===== sv/hpw_cfg_regs.sv =====
// configuration registers and derived drive limits
module hpw_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [hpw_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [hpw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output hpw_pkg::t_cfg                  o_cfg
);
    import hpw_pkg::*;

    logic [GAIN_W-1:0]     r_gain_p;
    logic [GAIN_W-1:0]     r_gain_i;
    logic [GAIN_W-1:0]     r_gain_d;
    logic [CENTER_W-1:0]   r_center;
    logic [MARGIN_W-1:0]   r_margin;
    logic [DEADBAND_W-1:0] r_deadband;
    logic [CENTER_W:0]     w_sum_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p   <= GAIN_P_RST;
            r_gain_i   <= GAIN_I_RST;
            r_gain_d   <= GAIN_D_RST;
            r_center   <= CENTER_RST;
            r_margin   <= MARGIN_RST;
            r_deadband <= DEADBAND_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_GAIN_P:          r_gain_p   <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:          r_gain_i   <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:          r_gain_d   <= i_cfg_data[GAIN_W-1:0];
                CFG_DRIVE_CENTER:    r_center   <= i_cfg_data[CENTER_W-1:0];
                CFG_DRIVE_MARGIN:    r_margin   <= i_cfg_data[MARGIN_W-1:0];
                CFG_DEADBAND_OFFSET: r_deadband <= i_cfg_data[DEADBAND_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_sum_lim = {1'b0, r_center} + (CENTER_W+1)'(r_margin);

    always_comb begin
        o_cfg.gain_p          = r_gain_p;
        o_cfg.gain_i          = r_gain_i;
        o_cfg.gain_d          = r_gain_d;
        o_cfg.drive_center    = r_center;
        o_cfg.deadband_offset = r_deadband;
        if (w_sum_lim > (CENTER_W+1)'(DRIVE_MAX)) begin
            o_cfg.drive_hi = DRIVE_W'(DRIVE_MAX);
        end else begin
            o_cfg.drive_hi = w_sum_lim[DRIVE_W-1:0];
        end
        if (CENTER_W'(r_margin) > r_center) begin
            o_cfg.drive_lo = '0;
        end else begin
            o_cfg.drive_lo = r_center - CENTER_W'(r_margin);
        end
    end
endmodule

// ===== sv/heading_pid_with_wrap_top.sv =====
// heading controller top level: unwrap, incremental pid, deadband, saturation
//
//  channel   dir  signals                                   request
//  i_req     in   valid ready measured_angle target_angle_in  one heading sample
//  o_rsp     out  valid ready drive_value clamped             one drive result
//  i_cfg_*   in   we idx data                                 register write
//
//  five register stages: input, error, products, sum, result
//  one request per cycle sustained while o_rsp.ready is high; an accepted request passes the error, products,
//  sum and result stages before o_rsp.valid rises; error history advances as a request leaves the input stage
//  a stage holds only when it is full and the stage after it is blocked
//  synchronous reset clears valid bits and history and loads the configuration reset values
module heading_pid_with_wrap_top #(
    parameter int ANGLE_FRAC_BITS = 7
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    hpw_req_if.sink                        i_req,
    hpw_rsp_if.source                      o_rsp,
    input  logic                           i_cfg_we,
    input  logic [hpw_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [hpw_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import hpw_pkg::*;
    `include "heading_pid_with_wrap_top_assert.svh"

    localparam int SUM_SHIFT = GAIN_FRAC_BITS + ANGLE_FRAC_BITS;
    localparam int DEG_W     = $clog2((360 << ANGLE_FRAC_BITS) + 1);
    localparam int UW        = ((DEG_W > ANGLE_W) ? DEG_W : ANGLE_W) + 2;
    localparam int DPW       = ERR_W + 1;
    localparam int DDW       = ERR_W + 2;
    localparam int PPW       = GAIN_W + 1 + DPW;
    localparam int PIW       = GAIN_W + 1 + ERR_W;
    localparam int PDW       = GAIN_W + 1 + DDW;
    localparam int SW        = PDW + 1;
    localparam int TW        = ((SUM_SHIFT + CENTER_W + 1 > SW) ? SUM_SHIFT + CENTER_W + 1 : SW)
                               + 1;
    localparam int DW        = TW - SUM_SHIFT;

    localparam logic signed [UW-1:0] DEG_40  = UW'(40 << ANGLE_FRAC_BITS);
    localparam logic signed [UW-1:0] DEG_320 = UW'(320 << ANGLE_FRAC_BITS);
    localparam logic signed [UW-1:0] DEG_360 = UW'(360 << ANGLE_FRAC_BITS);
    localparam logic signed [UW-1:0] ERR_HI  = UW'(ERR_MAX);
    localparam logic signed [UW-1:0] ERR_LO  = UW'(ERR_MIN);
    localparam logic signed [TW-1:0] RND     = TW'((64'd1 << SUM_SHIFT) - 64'd1);

    t_cfg w_cfg;

    hpw_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    logic r_v0, r_v1, r_v2, r_v3, r_vo;
    logic w_en0, w_en1, w_en2, w_en3, w_eno;

    assign w_eno = !r_vo || o_rsp.ready;
    assign w_en3 = !r_v3 || w_eno;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;
    assign w_en0 = !r_v0 || w_en1;
    assign i_req.ready = w_en0;

    logic [ANGLE_W-1:0]     r_meas, r_tgt;
    logic signed [ERR_W-1:0] r_e1, r_e2;
    logic signed [ERR_W-1:0] r_err1;
    logic signed [DPW-1:0]   r_dp1;
    logic signed [DDW-1:0]   r_dd1;
    logic signed [PPW-1:0]   r_pp;
    logic signed [PIW-1:0]   r_pi;
    logic signed [PDW-1:0]   r_pd;
    logic signed [SW-1:0]    r_sum;
    logic [DRIVE_W-1:0]      r_drive;
    logic                    r_clamped;

    // unwrap and error
    logic signed [UW-1:0]    w_meas, w_tgt, w_adj, w_diff;
    logic signed [ERR_W-1:0] w_err;
    logic signed [DPW-1:0]   w_dp;
    logic signed [DDW-1:0]   w_dd;

    always_comb begin
        w_meas = signed'(UW'(r_meas));
        w_tgt  = signed'(UW'(r_tgt));
        if (w_tgt < DEG_40 && w_meas > DEG_320 && w_meas < DEG_360) begin
            w_adj = w_meas - DEG_360;
        end else if (w_tgt > DEG_320 && w_tgt < DEG_360 && w_meas > 0 && w_meas < DEG_40) begin
            w_adj = w_meas + DEG_360;
        end else begin
            w_adj = w_meas;
        end
        w_diff = w_adj - w_tgt;
        if (w_diff > ERR_HI) begin
            w_err = ERR_W'(ERR_MAX);
        end else if (w_diff < ERR_LO) begin
            w_err = ERR_W'(ERR_MIN);
        end else begin
            w_err = w_diff[ERR_W-1:0];
        end
        w_dp = DPW'(w_err) - DPW'(r_e1);
        w_dd = DDW'(w_err) - (DDW'(r_e1) <<< 1) + DDW'(r_e2);
    end

    // products
    logic signed [PPW-1:0] w_pp;
    logic signed [PIW-1:0] w_pi;
    logic signed [PDW-1:0] w_pd;

    assign w_pp = signed'({1'b0, w_cfg.gain_p}) * r_dp1;
    assign w_pi = signed'({1'b0, w_cfg.gain_i}) * r_err1;
    assign w_pd = signed'({1'b0, w_cfg.gain_d}) * r_dd1;

    logic signed [SW-1:0] w_sum;
    assign w_sum = SW'(r_pp) + SW'(r_pi) + SW'(r_pd);

    // deadband, centre, truncation toward zero, saturation
    logic signed [TW-1:0] w_db, w_ctr, w_total, w_rnd;
    logic signed [DW-1:0] w_drive, w_lo, w_hi;
    logic [DRIVE_W-1:0]   n_drive;
    logic                 n_clamped;

    always_comb begin
        w_db  = signed'(TW'({w_cfg.deadband_offset, {SUM_SHIFT{1'b0}}}));
        w_ctr = signed'(TW'({w_cfg.drive_center, {SUM_SHIFT{1'b0}}}));
        if (r_sum > 0) begin
            w_total = w_ctr + TW'(r_sum) + w_db;
        end else if (r_sum < 0) begin
            w_total = w_ctr + TW'(r_sum) - w_db;
        end else begin
            w_total = w_ctr;
        end
        w_rnd   = w_total + (w_total[TW-1] ? RND : '0);
        w_drive = signed'(w_rnd[TW-1:SUM_SHIFT]);
        w_lo    = signed'(DW'(w_cfg.drive_lo));
        w_hi    = signed'(DW'(w_cfg.drive_hi));
        if (w_drive > w_hi) begin
            n_drive   = w_cfg.drive_hi;
            n_clamped = 1'b1;
        end else if (w_drive < w_lo) begin
            n_drive   = w_cfg.drive_lo;
            n_clamped = 1'b1;
        end else begin
            n_drive   = w_drive[DRIVE_W-1:0];
            n_clamped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
            r_e1 <= '0;
            r_e2 <= '0;
        end else begin
            if (w_en0) r_v0 <= i_req.valid;
            if (w_en1) r_v1 <= r_v0;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_eno) r_vo <= r_v3;
            if (w_en1 && r_v0) begin
                r_e1 <= w_err;
                r_e2 <= r_e1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en0 && i_req.valid) begin
            r_meas <= i_req.measured_angle;
            r_tgt  <= i_req.target_angle_in;
        end
        if (w_en1 && r_v0) begin
            r_err1 <= w_err;
            r_dp1  <= w_dp;
            r_dd1  <= w_dd;
        end
        if (w_en2 && r_v1) begin
            r_pp <= w_pp;
            r_pi <= w_pi;
            r_pd <= w_pd;
        end
        if (w_en3 && r_v2) begin
            r_sum <= w_sum;
        end
        if (w_eno && r_v3) begin
            r_drive   <= n_drive;
            r_clamped <= n_clamped;
        end
    end

    assign o_rsp.valid       = r_vo;
    assign o_rsp.drive_value = r_drive;
    assign o_rsp.clamped     = r_clamped;

    `HPW_ASSERT(a_drive_in_limits, i_clk, i_rst_n, r_vo |-> (r_drive >= w_cfg.drive_lo && r_drive <= w_cfg.drive_hi), "drive outside limits")
    `HPW_ASSERT(a_clamp_at_limit, i_clk, i_rst_n, (r_vo && r_clamped) |-> (r_drive == w_cfg.drive_lo || r_drive == w_cfg.drive_hi), "clamp flag without limit value")
    `HPW_ASSERT(a_history_shift, i_clk, i_rst_n, (w_en1 && r_v0) |=> (r_e2 == $past(r_e1) && r_e1 == $past(w_err)), "error history did not shift")
    `HPW_ASSERT_RST(a_reset_empty, i_clk, !i_rst_n |=> (!r_vo && !r_v0 && r_e1 == '0 && r_e2 == '0), "pipeline not empty after reset")
endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the heading controller: unwrap, incremental pid, saturation
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hpw_pkg::*;

    localparam int FRAC        = 7;
    localparam int SUM_SHIFT   = GAIN_FRAC_BITS + FRAC;
    localparam int DEG40       = 40 << FRAC;
    localparam int DEG320      = 320 << FRAC;
    localparam int DEG360      = 360 << FRAC;
    localparam int ANGLE_TOP   = DEG360 - 1;
    localparam int PIPE_LAT    = 5;
    localparam int PHASES      = 9;
    localparam int PHASE_REQS  = 150;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [DRIVE_W-1:0] drive_value;
        logic               clamped;
    } t_drive_result;

    typedef struct packed {
        logic [GAIN_W-1:0]     gain_p;
        logic [GAIN_W-1:0]     gain_i;
        logic [GAIN_W-1:0]     gain_d;
        logic [CENTER_W-1:0]   center;
        logic [MARGIN_W-1:0]   margin;
        logic [DEADBAND_W-1:0] deadband;
    } t_drive_setting;

    class heading_scoreboard;
        logic [GAIN_W-1:0]     gain_p, gain_i, gain_d;
        logic [CENTER_W-1:0]   center;
        logic [MARGIN_W-1:0]   margin;
        logic [DEADBAND_W-1:0] deadband;
        longint                err_back1, err_back2;
        t_drive_result         due_q[$];
        int unsigned           mismatches, checked, clamp_hits, requests;

        function new();
            gain_p     = GAIN_P_RST;
            gain_i     = GAIN_I_RST;
            gain_d     = GAIN_D_RST;
            center     = CENTER_RST;
            margin     = MARGIN_RST;
            deadband   = DEADBAND_RST;
            err_back1  = 0;
            err_back2  = 0;
            mismatches = 0;
            checked    = 0;
            clamp_hits = 0;
            requests   = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_GAIN_P:          gain_p   = data;
                CFG_GAIN_I:          gain_i   = data;
                CFG_GAIN_D:          gain_d   = data;
                CFG_DRIVE_CENTER:    center   = data[CENTER_W-1:0];
                CFG_DRIVE_MARGIN:    margin   = data[MARGIN_W-1:0];
                CFG_DEADBAND_OFFSET: deadband = data[DEADBAND_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        function void note_request(logic [ANGLE_W-1:0] meas_in, logic [ANGLE_W-1:0] tgt_in);
            longint        meas, tgt, err, corr, total, drive, lo, hi;
            t_drive_result res;
            meas = longint'(meas_in);
            tgt  = longint'(tgt_in);
            // unwrap across the 0/360 seam
            if (tgt < DEG40 && meas > DEG320 && meas < DEG360)
                meas = meas - DEG360;
            if (tgt > DEG320 && tgt < DEG360 && meas > 0 && meas < DEG40)
                meas = meas + DEG360;
            err = meas - tgt;
            if (err > ERR_MAX) err = ERR_MAX;
            if (err < ERR_MIN) err = ERR_MIN;
            corr = longint'(gain_p) * (err - err_back1)
                 + longint'(gain_i) * err
                 + longint'(gain_d) * (err - 2 * err_back1 + err_back2);
            if (corr > 0)
                corr = corr + (longint'(deadband) <<< SUM_SHIFT);
            else if (corr < 0)
                corr = corr - (longint'(deadband) <<< SUM_SHIFT);
            total = (longint'(center) <<< SUM_SHIFT) + corr;
            // truncation toward zero
            if (total >= 0)
                drive = total >>> SUM_SHIFT;
            else
                drive = -((-total) >>> SUM_SHIFT);
            hi = longint'(center) + longint'(margin);
            if (hi > DRIVE_MAX) hi = DRIVE_MAX;
            lo = longint'(center) - longint'(margin);
            if (lo < 0) lo = 0;
            res.clamped = 1'b0;
            if (drive > hi) begin
                drive = hi;
                res.clamped = 1'b1;
            end
            if (drive < lo) begin
                drive = lo;
                res.clamped = 1'b1;
            end
            res.drive_value = drive[DRIVE_W-1:0];
            err_back2 = err_back1;
            err_back1 = err;
            due_q.push_back(res);
            requests++;
        endfunction

        function void check_result(logic [DRIVE_W-1:0] drive_value, logic clamped);
            t_drive_result exp_res;
            if (due_q.size() == 0) begin
                $error("drive result with no request waiting: drive_value %0d clamped %0b",
                       drive_value, clamped);
                mismatches++;
                return;
            end
            exp_res = due_q.pop_front();
            checked++;
            if (exp_res.clamped) clamp_hits++;
            if (drive_value !== exp_res.drive_value) begin
                $error("drive_value mismatch: expected %0d, actual %0d",
                       exp_res.drive_value, drive_value);
                mismatches++;
            end
            if (clamped !== exp_res.clamped) begin
                $error("clamped mismatch: expected %0b, actual %0b", exp_res.clamped, clamped);
                mismatches++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    burst_left;
    int                    directed_reqs;

    hpw_req_if req_ch();
    hpw_rsp_if rsp_ch();

    heading_scoreboard board;

    heading_pid_with_wrap_top #(
        .ANGLE_FRAC_BITS(FRAC)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $error("timeout with %0d drive results outstanding", board.pending());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            board.check_result(rsp_ch.drive_value, rsp_ch.clamped);
    end

    // receiver stall pattern: free runs, coin flips and long stalls
    initial begin
        int run_len;
        int mode;
        rsp_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            run_len = $urandom_range(4, 60);
            mode    = $urandom_range(0, 2);
            repeat (run_len) begin
                @(negedge i_clk);
                case (mode)
                    0:       rsp_ch.ready = 1'b1;
                    1:       rsp_ch.ready = 1'($urandom_range(0, 1));
                    default: rsp_ch.ready = ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    task automatic hold_sender();
        @(negedge i_clk);
        req_ch.valid           = 1'b0;
        req_ch.measured_angle  = ANGLE_W'($urandom_range(0, 65535));
        req_ch.target_angle_in = ANGLE_W'($urandom_range(0, 65535));
    endtask

    task automatic send_heading(input logic [ANGLE_W-1:0] meas, input logic [ANGLE_W-1:0] tgt);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                hold_sender();
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        req_ch.valid           = 1'b1;
        req_ch.measured_angle  = meas;
        req_ch.target_angle_in = tgt;
        do @(posedge i_clk); while (!req_ch.ready);
        board.note_request(meas, tgt);
    endtask

    task automatic wait_drained();
        hold_sender();
        while (board.pending() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(posedge i_clk);
        board.set_reg(idx, data);
        @(negedge i_clk);
        cfg_we   = 1'b0;
    endtask

    task automatic apply_setting(input t_drive_setting s);
        write_reg(CFG_GAIN_P, s.gain_p);
        write_reg(CFG_GAIN_I, s.gain_i);
        write_reg(CFG_GAIN_D, s.gain_d);
        write_reg(CFG_DRIVE_CENTER, CFG_DATA_W'(s.center));
        write_reg(CFG_DRIVE_MARGIN, CFG_DATA_W'(s.margin));
        write_reg(CFG_DEADBAND_OFFSET, CFG_DATA_W'(s.deadband));
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain();
        return GAIN_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                    : $urandom_range(0, 600));
    endfunction

    function automatic t_drive_setting pick_setting(int phase);
        t_drive_setting s;
        s.gain_p   = pick_gain();
        s.gain_i   = pick_gain();
        s.gain_d   = pick_gain();
        s.center   = CENTER_W'($urandom_range(0, 1023));
        s.margin   = MARGIN_W'($urandom_range(0, 511));
        s.deadband = DEADBAND_W'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 255)
                                                              : $urandom_range(0, 20));
        case (phase)
            0: s = '0;
            1: s = '1;
            2: begin
                // negative sums near zero
                s.center = '0;
                s.margin = '1;
                s.gain_p = GAIN_W'($urandom_range(0, 300));
                s.gain_i = GAIN_W'($urandom_range(0, 300));
                s.gain_d = GAIN_W'($urandom_range(0, 300));
            end
            3: begin
                s.center = '1;
                s.margin = '1;
            end
            default: ;
        endcase
        return s;
    endfunction

    // mostly small errors around the target, plus seam crossings and raw noise
    task automatic pick_heading(output logic [ANGLE_W-1:0] meas, output logic [ANGLE_W-1:0] tgt);
        int sel;
        int v;
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
            tgt = ANGLE_W'($urandom_range(0, ANGLE_TOP));
            v   = int'(tgt) + ($urandom_range(0, 3) == 0 ? $urandom_range(0, 4096) - 2048
                                                         : $urandom_range(0, 256) - 128);
            if (v < 0) v = v + DEG360;
            if (v > ANGLE_TOP) v = v - DEG360;
            meas = ANGLE_W'(v);
        end else if (sel < 75) begin
            if ($urandom_range(0, 1)) begin
                tgt  = ANGLE_W'($urandom_range(0, DEG40 - 1));
                meas = ANGLE_W'($urandom_range(DEG320 + 1, ANGLE_TOP));
            end else begin
                tgt  = ANGLE_W'($urandom_range(DEG320 + 1, ANGLE_TOP));
                meas = ANGLE_W'($urandom_range(1, DEG40 - 1));
            end
        end else if (sel < 90) begin
            tgt  = ANGLE_W'($urandom_range(0, 65535));
            meas = ANGLE_W'($urandom_range(0, 65535));
        end else begin
            tgt  = ANGLE_W'($urandom_range(0, ANGLE_TOP));
            meas = ANGLE_W'($urandom_range(0, ANGLE_TOP));
        end
    endtask

    initial begin
        t_drive_setting       s;
        logic [ANGLE_W-1:0]   meas, tgt;
        board          = new();
        burst_left     = 0;
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = '0;
        cfg_data       = '0;
        req_ch.valid           = 1'b0;
        req_ch.measured_angle  = '0;
        req_ch.target_angle_in = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed requests at reset settings
        send_heading(16'd0, 16'd0);
        send_heading(ANGLE_W'(ANGLE_TOP), ANGLE_W'(ANGLE_TOP));
        send_heading(16'd0, ANGLE_W'(ANGLE_TOP));
        send_heading(ANGLE_W'(ANGLE_TOP), 16'd0);
        send_heading(16'hFFFF, 16'd0);
        send_heading(16'd0, 16'hFFFF);
        send_heading(16'hFFFF, 16'hFFFF);
        send_heading(ANGLE_W'(DEG320 + 1), ANGLE_W'(DEG40 - 1));
        send_heading(ANGLE_W'(DEG320), ANGLE_W'(DEG40 - 1));
        send_heading(ANGLE_W'(DEG320 + 1), ANGLE_W'(DEG40));
        send_heading(ANGLE_W'(DEG360), 16'd100);
        send_heading(16'd1, ANGLE_W'(DEG320 + 1));
        send_heading(ANGLE_W'(DEG40 - 1), ANGLE_W'(ANGLE_TOP));
        send_heading(ANGLE_W'(DEG40), ANGLE_W'(DEG320 + 1));
        send_heading(16'd1, ANGLE_W'(DEG320));
        send_heading(16'd1, ANGLE_W'(DEG360));
        wait_drained();

        // deadband around a zero correction and truncation of small negatives
        write_reg(CFG_DEADBAND_OFFSET, 16'd5);
        write_reg(CFG_GAIN_I, 16'd128);
        write_reg(CFG_SPARE_6, 16'hFFFF);
        write_reg(CFG_SPARE_7, 16'h1234);
        send_heading(16'd1000, 16'd1000);
        send_heading(16'd1000, 16'd1000);
        send_heading(16'd1001, 16'd1000);
        send_heading(16'd999, 16'd1000);
        send_heading(16'd1000, 16'd1000);
        send_heading(16'd999, 16'd1000);
        wait_drained();
        directed_reqs = board.requests;

        for (int phase = 0; phase < PHASES; phase++) begin
            s = pick_setting(phase);
            apply_setting(s);
            if (phase == 4) write_reg(CFG_SPARE_7, CFG_DATA_W'($urandom_range(0, 65535)));
            for (int n = 0; n < PHASE_REQS; n++) begin
                if (n == PHASE_REQS / 2) wait_drained();
                pick_heading(meas, tgt);
                send_heading(meas, tgt);
            end
            wait_drained();
        end

        $display("run covered %0d directed and %0d random heading requests over %0d settings",
                 directed_reqs, board.requests - directed_reqs, PHASES + 2);
        $display("%0d drive results checked, %0d of them clamped", board.checked,
                 board.clamp_hits);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
